/* rtl/gne_pkg.sv */
// gne_pkg: shared constants, gate kind codes, register indexes and types
// for the gate netlist evaluator; no dependencies
package gne_pkg;

    localparam int MAX_GATES  = 64;
    localparam int MAX_NETS   = 64;
    localparam int MAX_INPUTS = 16;

    localparam int NET_W     = $clog2(MAX_NETS);
    localparam int GATE_AW   = $clog2(MAX_GATES);
    localparam int KIND_W    = 3;
    localparam int IN_BITS_W = 16;
    localparam int GCNT_W    = 7;
    localparam int ICNT_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    // stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;
    localparam int OUT_W     = 4;

    // gate kinds
    localparam logic [KIND_W-1:0] K_AND = 3'd0;
    localparam logic [KIND_W-1:0] K_OR  = 3'd1;
    localparam logic [KIND_W-1:0] K_NOT = 3'd2;
    localparam logic [KIND_W-1:0] K_TFF = 3'd3;
    localparam logic [KIND_W-1:0] K_DEC = 3'd4;

    // command carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_NET  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NET_W-1:0]  dest;
        logic [NET_W-1:0]  src_a;
        logic [NET_W-1:0]  src_b;
    } t_entry;

endpackage

/* rtl/gate_netlist_evaluator.sv */
// gate_netlist_evaluator: gate table memory, net vector and a sequencer that
// walks the table one gate per cycle through a shared gate evaluation unit
// depends on gne_pkg
//
//  channel  dir  fields
//  s_*      in   tuser: cmd; tdata: gate_slot, gate_kind, dest_net, src_a, src_b,
//                input_bits
//  m_*      out  tuser: out_is_decoder; tdata: out_bits
//  i_cfg_*  in   index 0 gate_count, 1 input_count, 2 output_net
//
// a load request is written to the table and the block is ready again at once
// an evaluate request walks the first gate_count entries (at most 64): one table read
// per cycle, the gate unit works on the entry read the cycle before
// a finished result sits in the output register; the next request is taken
// while it waits, and the sequencer holds in its done state if it is not taken
// synchronous reset clears the nets, the flags, gate_count and output_net and sets input_count to 1
module gate_netlist_evaluator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [5:0] gate_slot, [8:6] gate_kind, [14:9] dest_net, [20:15] src_a,
    // [26:21] src_b, [42:27] input_bits, [47:43] zero
    input  logic [gne_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] out_bits, [7:4] zero
    output logic [gne_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] out_is_decoder
    output logic                          m_tuser,
    input  logic                          i_cfg_we,
    input  logic [gne_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gne_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import gne_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [GCNT_W-1:0]   r_g, n_g;
    logic [GCNT_W-1:0]   r_n, n_n;
    logic                r_ex_vld;
    t_entry              r_entry;
    t_entry              r_table [MAX_GATES];
    logic [MAX_NETS-1:0] r_nets, n_nets;
    logic                r_dec_seen, n_dec_seen;
    logic [OUT_W-1:0]    r_dec_bits, n_dec_bits;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out_bits;
    logic                r_out_dec;
    logic [GCNT_W-1:0]   r_gate_count;
    logic [ICNT_W-1:0]   r_input_count;
    logic [NET_W-1:0]    r_output_net;

    logic                  w_acc;
    logic                  w_load;
    logic                  w_eval;
    logic                  w_fetch;
    logic                  w_out_load;
    logic [5:0]            w_slot;
    t_entry                w_new;
    logic [IN_BITS_W-1:0]  w_in_bits;
    logic [ICNT_W-1:0]     w_ins;
    logic [GCNT_W-1:0]     w_nsat;

    assign s_tready   = (r_state == ST_IDLE);
    assign w_acc      = s_tvalid && s_tready;
    assign w_load     = w_acc && (s_tuser == CMD_LOAD);
    assign w_eval     = w_acc && (s_tuser == CMD_EVAL);
    assign w_slot     = s_tdata[5:0];
    // tdata carries kind below dest and the sources, the table entry keeps kind in its top bits
    assign w_new      = {s_tdata[8:6], s_tdata[14:9], s_tdata[20:15], s_tdata[26:21]};
    assign w_in_bits  = s_tdata[42:27];
    assign w_fetch    = (r_state == ST_RUN) && (r_g < r_n);
    assign w_out_load = (r_state == ST_DONE) && (!r_out_vld || m_tready);

    assign w_ins  = (r_input_count > ICNT_W'(MAX_INPUTS)) ? ICNT_W'(MAX_INPUTS)
                                                          : r_input_count;
    assign w_nsat = (r_gate_count > GCNT_W'(MAX_GATES)) ? GCNT_W'(MAX_GATES)
                                                        : r_gate_count;

    // gate table: one write port for loads, one registered read for the walk
    always_ff @(posedge i_clk) begin
        if (w_load && ({1'b0, w_slot} < GCNT_W'(MAX_GATES))) begin
            r_table[w_slot[GATE_AW-1:0]] <= w_new;
        end
        if (w_fetch) begin
            r_entry <= r_table[r_g[GATE_AW-1:0]];
        end
    end

    // shared gate unit and input apply
    always_comb begin
        logic             v_a;
        logic             v_b;
        logic             v_d;
        logic [1:0]       v_sel;
        logic [NET_W-1:0] v_idx;
        n_nets     = r_nets;
        n_dec_seen = r_dec_seen;
        n_dec_bits = r_dec_bits;
        v_a   = r_nets[r_entry.src_a];
        v_b   = r_nets[r_entry.src_b];
        v_d   = r_nets[r_entry.dest];
        v_sel = {v_a, v_b};
        v_idx = '0;
        if (w_eval) begin
            for (int k = 0; k < IN_BITS_W; k++) begin
                if (ICNT_W'(k) < w_ins) begin
                    n_nets[k] = w_in_bits[k];
                end
            end
            n_dec_seen = 1'b0;
        end else if ((r_state == ST_RUN) && r_ex_vld) begin
            unique case (r_entry.kind)
                K_AND: n_nets[r_entry.dest] = v_a & v_b;
                K_OR:  n_nets[r_entry.dest] = v_a | v_b;
                K_NOT: n_nets[r_entry.dest] = ~v_a;
                K_TFF: n_nets[r_entry.dest] = v_a ^ v_d;
                K_DEC: begin
                    for (int x = 0; x < 4; x++) begin
                        v_idx = r_entry.dest + NET_W'(x);
                        n_nets[v_idx] = (v_sel == 2'(x));
                    end
                    n_dec_bits = OUT_W'(1) << v_sel;
                    n_dec_seen = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_g     = r_g;
        n_n     = r_n;
        unique case (r_state)
            ST_IDLE: begin
                if (w_eval) begin
                    n_state = ST_RUN;
                    n_g     = '0;
                    n_n     = w_nsat;
                end
            end
            ST_RUN: begin
                if (w_fetch) begin
                    n_g = r_g + GCNT_W'(1);
                end else if (!r_ex_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_g           <= '0;
            r_n           <= '0;
            r_ex_vld      <= 1'b0;
            r_nets        <= '0;
            r_dec_seen    <= 1'b0;
            r_dec_bits    <= '0;
            r_out_vld     <= 1'b0;
            r_gate_count  <= '0;
            r_input_count <= ICNT_W'(1);
            r_output_net  <= '0;
        end else begin
            r_state    <= n_state;
            r_g        <= n_g;
            r_n        <= n_n;
            r_ex_vld   <= w_fetch;
            r_nets     <= n_nets;
            r_dec_seen <= n_dec_seen;
            r_dec_bits <= n_dec_bits;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GATE_COUNT:  r_gate_count  <= i_cfg_data;
                    REG_INPUT_COUNT: r_input_count <= i_cfg_data[ICNT_W-1:0];
                    REG_OUTPUT_NET:  r_output_net  <= i_cfg_data[NET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_dec_seen) begin
                r_out_bits <= r_dec_bits;
                r_out_dec  <= 1'b1;
            end else begin
                r_out_bits <= {{(OUT_W-1){1'b0}}, r_nets[r_output_net]};
                r_out_dec  <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, r_out_bits};
    assign m_tuser  = r_out_dec;

endmodule

/* rtl/gne_checker.sv */
// gne_checker: port-level assertions for gate_netlist_evaluator and its bind
// depends on gne_pkg and gate_netlist_evaluator
module gne_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gne_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import gne_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // decoder results are one-hot
    a_dec_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> $onehot(m_tdata[OUT_W-1:0]))
        else $error("decoder result not one-hot");

    // plain results carry only bit 0
    a_plain_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("plain result has upper bits set");

    // a load finishes in its own cycle
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
        else $error("not ready after load");

    // an evaluate request occupies the sequencer
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_EVAL) |=> !s_tready)
        else $error("ready right after evaluate");

endmodule

bind gate_netlist_evaluator gne_checker u_gne_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* bench/tb_top.sv */
// tb_top: self-checking bench for gate_netlist_evaluator; streams gate loads and
// input vectors, predicts every result with an in-bench netlist model and checks it
// depends on gne_pkg and the gate_netlist_evaluator rtl
module tb_top;
    import gne_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_CYCLES = 600;
    localparam int PHASE_ITEMS  = 46;

    typedef struct packed {
        logic              cmd;
        logic [GATE_AW-1:0] slot;
        logic [KIND_W-1:0] kind;
        logic [NET_W-1:0]  dest;
        logic [NET_W-1:0]  src_a;
        logic [NET_W-1:0]  src_b;
        logic [15:0]       in_bits;
    } t_request;

    typedef struct packed {
        logic [OUT_W-1:0] bits;
        logic             from_dec;
    } t_outcome;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata    = '0;
    logic                 s_tuser    = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // netlist model state
    t_entry              gate_rows [MAX_GATES];
    logic [MAX_NETS-1:0] net_vals;
    logic [GCNT_W-1:0]   cfg_gates;
    logic [ICNT_W-1:0]   cfg_inputs;
    logic [NET_W-1:0]    cfg_out_net;

    t_request request_queue [$];
    t_outcome expected_outputs [$];
    t_request in_flight;
    t_outcome want;

    int  n_queued, n_accepted, n_evals, n_loads, n_checked, n_decoded, n_errors;
    int  send_idle, recv_idle, stall_left, cycles;
    bit  stall_done;

    gate_netlist_evaluator i_dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // applies one accepted request to the model, queues the result of a vector
    task automatic apply_request(input t_request rq);
        int               n_in;
        int               n_g;
        t_entry           e;
        logic [1:0]       sel;
        logic [NET_W-1:0] d;
        t_outcome         res;
        if (rq.cmd == CMD_LOAD) begin
            gate_rows[rq.slot] = {rq.kind, rq.dest, rq.src_a, rq.src_b};
            n_loads++;
            return;
        end
        n_in = (cfg_inputs > MAX_INPUTS) ? MAX_INPUTS : int'(cfg_inputs);
        for (int k = 0; k < n_in; k++) net_vals[k] = rq.in_bits[k];
        n_g = (cfg_gates > MAX_GATES) ? MAX_GATES : int'(cfg_gates);
        res = '0;
        for (int g = 0; g < n_g; g++) begin
            e = gate_rows[g];
            case (e.kind)
                K_AND: net_vals[e.dest] = net_vals[e.src_a] & net_vals[e.src_b];
                K_OR:  net_vals[e.dest] = net_vals[e.src_a] | net_vals[e.src_b];
                K_NOT: net_vals[e.dest] = ~net_vals[e.src_a];
                K_TFF: net_vals[e.dest] = net_vals[e.src_a] ^ net_vals[e.dest];
                K_DEC: begin
                    // select is taken before any of the four nets is written
                    sel = {net_vals[e.src_a], net_vals[e.src_b]};
                    for (int x = 0; x < 4; x++) begin
                        d = e.dest + NET_W'(x);
                        net_vals[d] = (x == sel);
                    end
                    res.bits     = 4'b0001 << sel;
                    res.from_dec = 1'b1;
                end
                default: ;
            endcase
        end
        if (!res.from_dec) res.bits = {3'b000, net_vals[cfg_out_net]};
        expected_outputs.push_back(res);
        n_evals++;
        if (res.from_dec) n_decoded++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(in_flight);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
                    in_flight = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= in_flight.cmd;
                    s_tdata  <= {5'b0, in_flight.in_bits, in_flight.src_b, in_flight.src_a,
                                 in_flight.dest, in_flight.kind, in_flight.slot};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_outputs.size() == 0) begin
                    $display("%0t: unexpected result, out_bits %h out_is_decoder %b",
                             $time, m_tdata[OUT_W-1:0], m_tuser);
                    n_errors++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want.bits) begin
                        $display("%0t: out_bits expected %h actual %h",
                                 $time, want.bits, m_tdata[OUT_W-1:0]);
                        n_errors++;
                    end
                    if (m_tuser !== want.from_dec) begin
                        $display("%0t: out_is_decoder expected %b actual %b",
                                 $time, want.from_dec, m_tuser);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!stall_done && n_checked >= 60 && request_queue.size() > 4) begin
                // long hold-off so the output register fills and input stalls
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[gate_netlist_evaluator] ERROR");
            $finish;
        end
    end

    task automatic push_request(input t_request rq);
        request_queue.push_back(rq);
        n_queued++;
    endtask

    task automatic push_load(input int slot, input logic [KIND_W-1:0] kind,
                             input int dest, input int a, input int b);
        t_request   rq;
        logic [63:0] noise;
        noise      = {$urandom(), $urandom()};
        rq         = noise[$bits(t_request)-1:0];
        rq.cmd     = CMD_LOAD;
        rq.slot    = GATE_AW'(slot);
        rq.kind    = kind;
        rq.dest    = NET_W'(dest);
        rq.src_a   = NET_W'(a);
        rq.src_b   = NET_W'(b);
        push_request(rq);
    endtask

    task automatic push_eval(input logic [15:0] bits);
        t_request    rq;
        logic [63:0] noise;
        noise      = {$urandom(), $urandom()};
        rq         = noise[$bits(t_request)-1:0];
        rq.cmd     = CMD_EVAL;
        rq.in_bits = bits;
        push_request(rq);
    endtask

    task automatic push_random_gate(input int slot, input bit allow_dec);
        int                r;
        logic [KIND_W-1:0] kind;
        r = $urandom_range(0, 15);
        if (r < 13) kind = KIND_W'(r % 4);
        else if (r == 13) kind = allow_dec ? K_DEC : K_TFF;
        else kind = KIND_W'($urandom_range(5, 7));
        push_load(slot, kind, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 63));
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_outputs.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_GATE_COUNT:  cfg_gates   = val[GCNT_W-1:0];
            REG_INPUT_COUNT: cfg_inputs  = val[ICNT_W-1:0];
            REG_OUTPUT_NET:  cfg_out_net = val[NET_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_regs(input int gates, input int inputs, input int out_net);
        wait_drained();
        // a trailing load is written into the table when it is accepted, not by the sequencer
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(REG_GATE_COUNT, CFG_DAT_W'(gates));
        write_reg(REG_INPUT_COUNT, CFG_DAT_W'(inputs));
        write_reg(REG_OUTPUT_NET, CFG_DAT_W'(out_net));
    endtask

    initial begin
        int first_dec;
        int gc;
        int ic;
        int r;
        bit no_dec;
        net_vals    = '0;
        cfg_gates   = '0;
        cfg_inputs  = ICNT_W'(1);
        cfg_out_net = '0;
        send_idle   = 23;
        recv_idle   = 78;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no gates yet: output follows input bit 0
        push_eval(16'hFFFE);
        push_eval(16'h0001);
        push_load(0, K_AND, 16, 0, 1);
        push_load(1, K_OR, 17, 2, 3);
        push_load(2, K_NOT, 18, 16, 0);
        push_load(3, K_TFF, 19, 17, 0);
        // unknown kind with every field at its top value
        push_load(4, 3'd7, 63, 63, 63);
        // decoder at net 62 wraps onto nets 0 and 1
        push_load(5, K_DEC, 62, 18, 19);
        push_load(63, K_AND, 20, 0, 0);
        set_regs(5, 16, 19);
        push_eval(16'h0000);
        push_eval(16'hFFFF);
        push_eval(16'h0002);
        push_eval(16'h0002);
        // no primary inputs driven, decoder now in range
        set_regs(6, 0, 63);
        push_eval(16'hAAAA);
        push_eval(16'h5555);
        push_eval(16'h0000);

        // every slot written so any gate count is legal from here on
        for (int s = 0; s < MAX_GATES; s++) push_random_gate(s, 1'b1);

        for (int p = 0; p < 9; p++) begin
            no_dec = (p % 3 == 2);
            wait_drained();
            case (p / 3)
                0: begin send_idle = 23; recv_idle = 78; end
                1: begin send_idle = 78; recv_idle = 23; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            case (p % 4)
                0: gc = MAX_GATES;
                1: gc = 127;
                2: gc = $urandom_range(1, 12);
                default: gc = $urandom_range(0, 127);
            endcase
            if (no_dec) begin
                // keep the walk short of the first decoder so output_net shows
                first_dec = MAX_GATES;
                for (int g = MAX_GATES - 1; g >= 0; g--)
                    if (gate_rows[g].kind == K_DEC) first_dec = g;
                gc = $urandom_range(0, first_dec);
            end
            case (p % 3)
                0: ic = 16;
                1: ic = 31;
                default: ic = $urandom_range(0, 31);
            endcase
            set_regs(gc, ic, (p == 0) ? 63 : (p == 1) ? 0 : $urandom_range(0, 63));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 9);
                if (r < 3) push_random_gate($urandom_range(0, 63), !no_dec);
                else if (r == 3) push_eval(16'h0000);
                else if (r == 4) push_eval(16'hFFFF);
                else push_eval(16'($urandom_range(0, 65535)));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_outputs.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_outputs.size());
            n_errors++;
        end
        $display("run: %0d requests (%0d gate loads, %0d vectors), %0d results checked",
                 n_accepted, n_loads, n_evals, n_checked);
        $display("run: %0d vectors ended in a decoder, %0d mismatches", n_decoded, n_errors);
        if (n_errors == 0) begin
            $display("[gate_netlist_evaluator] OK");
        end else begin
            $display("[gate_netlist_evaluator] ERROR");
        end
        $finish;
    end

endmodule
